### src/smeu_pkg.sv
// Shared types and constants for the stack machine execute unit.
// Depends on nothing; every other file in src except smeu_ram imports it.
package smeu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int WORD_BITS   = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W       = (LVL_W > 16) ? LVL_W + 1 : 17;
  localparam int IN_W        = 24;
  localparam int OUT_W       = 48;

  typedef enum logic [4:0] {
    OP_HLT  = 5'd0,  OP_NOP  = 5'd1,  OP_NEG  = 5'd2,  OP_ADD  = 5'd3,
    OP_SUB  = 5'd4,  OP_MUL  = 5'd5,  OP_DIV  = 5'd6,  OP_MOD  = 5'd7,
    OP_NOT  = 5'd8,  OP_OR   = 5'd9,  OP_AND  = 5'd10, OP_XOR  = 5'd11,
    OP_SHL  = 5'd12, OP_SHR  = 5'd13, OP_POP  = 5'd14, OP_RET  = 5'd15,
    OP_JMP  = 5'd16, OP_JMPT = 5'd17, OP_JMPF = 5'd18, OP_CALL = 5'd19,
    OP_EQ   = 5'd20, OP_NEQ  = 5'd21, OP_LT   = 5'd22, OP_LE   = 5'd23,
    OP_GT   = 5'd24, OP_GE   = 5'd25, OP_GET  = 5'd26, OP_SET  = 5'd27,
    OP_IMM  = 5'd28
  } op_e;

  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_UNDER = 3'd1,
    FLT_OVER  = 3'd2,
    FLT_DIVZ  = 3'd3,
    FLT_INDEX = 3'd4
  } fault_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_TOP, ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_commit;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

### src/smeu_ram.sv
// Generic RAM with one write port and two registered read ports.
// Standalone; no package needed.
module smeu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

### src/smeu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Uses smeu_pkg for the word width.
module smeu_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [smeu_pkg::WORD_BITS-1:0] dividend_i,
  input  logic [smeu_pkg::WORD_BITS-1:0] divisor_i,
  output logic                           done_o,
  output logic [smeu_pkg::WORD_BITS-1:0] quot_o,
  output logic [smeu_pkg::WORD_BITS-1:0] rem_o
);
  import smeu_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic                 busy_q, busy_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [WORD_BITS-1:0] quo_q, quo_d, rem_q, rem_d, dsr_q, dsr_d;
  logic                 qneg_q, qneg_d, rneg_q, rneg_d;
  logic [WORD_BITS:0]   shifted, trial;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    qneg_d  = qneg_q;
    rneg_d  = rneg_q;
    shifted = {rem_q, quo_q[WORD_BITS-1]};
    trial   = shifted - {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WORD_BITS);
      quo_d  = dividend_i[WORD_BITS-1] ? (~dividend_i + 1'b1) : dividend_i;
      dsr_d  = divisor_i[WORD_BITS-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_d  = '0;
      qneg_d = dividend_i[WORD_BITS-1] ^ divisor_i[WORD_BITS-1];
      rneg_d = dividend_i[WORD_BITS-1];
    end else if (busy_q) begin
      if (!trial[WORD_BITS]) begin
        rem_d = trial[WORD_BITS-1:0];
      end else begin
        rem_d = shifted[WORD_BITS-1:0];
      end
      quo_d = {quo_q[WORD_BITS-2:0], ~trial[WORD_BITS]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
    end
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? (~quo_q + 1'b1) : quo_q;
  assign rem_o  = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule

### src/smeu_ctrl.sv
// Sequencing state machine of the execute unit.
// Uses smeu_pkg for the state type and the command and status structs.
module smeu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  smeu_pkg::ctrl_sts_t sts_i,
  output smeu_pkg::ctrl_cmd_t cmd_o
);
  import smeu_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = sts_i.need_div ? ST_DIV : ST_TOP;
      ST_DIV:  if (sts_i.div_done) state_d = ST_TOP;
      ST_TOP:  state_d = ST_FIN;
      ST_FIN:  if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    cmd_o.load       = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec       = (state_q == ST_EXEC);
    cmd_o.div_commit = (state_q == ST_DIV) && sts_i.div_done;
    cmd_o.out_load   = (state_q == ST_FIN) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_EXEC)
    else $error("load not followed by execute");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_commit |=> state_q == ST_TOP)
    else $error("divide commit not followed by top read");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> state_q == ST_IDLE)
    else $error("output load did not return to idle");

endmodule

### src/smeu_datapath.sv
// Datapath: stack RAM, level, pc and halt registers, ALU, divider, output register.
// Uses smeu_pkg, smeu_ram and smeu_div.
module smeu_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [smeu_pkg::IN_W-1:0]  in_data_i,
  input  smeu_pkg::ctrl_cmd_t        cmd_i,
  output smeu_pkg::ctrl_sts_t        sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [smeu_pkg::OUT_W-1:0] out_data_o
);
  import smeu_pkg::*;

  localparam int W = WORD_BITS;

  logic [LVL_W-1:0] level_q, level_d;
  logic [W-1:0]     pc_q, pc_d;
  logic             halt_q, halt_d;
  fault_e           fault_q, fault_d;
  op_e              op_q;
  logic [W-1:0]     opnd_q;
  logic             ovalid_q;
  logic [OUT_W-1:0] odata_q;

  logic [W-1:0]      rd0, rd1, quot, rem;
  logic              div_done, we;
  logic [ADDR_W-1:0] waddr, raddr0, raddr1;
  logic [W-1:0]      wdata;

  logic [4:0]       in_cmd;
  logic [W-1:0]     in_opnd;
  logic [CMP_W-1:0] lvl_x, opnd_x, in_opnd_x;

  assign in_cmd    = in_data_i[4:0];
  assign in_opnd   = in_data_i[W+4:5];
  assign lvl_x     = CMP_W'(level_q);
  assign opnd_x    = CMP_W'(opnd_q);
  assign in_opnd_x = CMP_W'(in_opnd);

  assign raddr0 = ADDR_W'(level_q - 1'b1);
  always_comb begin
    if (in_cmd == OP_GET) begin
      raddr1 = ADDR_W'(lvl_x - CMP_W'(1) - in_opnd_x);
    end else begin
      raddr1 = ADDR_W'(level_q - LVL_W'(2));
    end
  end

  smeu_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  logic div_start;
  smeu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd1),
    .divisor_i  (rd0),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  logic [W-1:0] npc, jpc, alu, shl_v, shr_v;
  logic [2*W-1:0] prod;
  logic         lt, eq, need_div;

  assign npc   = pc_q + 1'b1;
  assign jpc   = npc + opnd_q;
  assign prod  = rd1 * rd0;
  assign lt    = $signed(rd1) < $signed(rd0);
  assign eq    = (rd1 == rd0);
  assign shl_v = (opnd_q >= W'(W)) ? '0 : (rd0 << opnd_q[3:0]);
  assign shr_v = (opnd_q >= W'(W)) ? {W{rd0[W-1]}}
                                   : W'($signed(rd0) >>> opnd_q[3:0]);

  always_comb begin
    unique case (op_q)
      OP_ADD:  alu = rd1 + rd0;
      OP_SUB:  alu = rd1 - rd0;
      OP_MUL:  alu = prod[W-1:0];
      OP_OR:   alu = rd1 | rd0;
      OP_AND:  alu = rd1 & rd0;
      OP_XOR:  alu = rd1 ^ rd0;
      OP_EQ:   alu = W'(eq);
      OP_NEQ:  alu = W'(!eq);
      OP_LT:   alu = W'(lt);
      OP_LE:   alu = W'(lt || eq);
      OP_GT:   alu = W'(!(lt || eq));
      default: alu = W'(!lt);
    endcase
  end

  always_comb begin
    level_d  = level_q;
    pc_d     = pc_q;
    halt_d   = halt_q;
    fault_d  = fault_q;
    we       = 1'b0;
    waddr    = ADDR_W'(level_q);
    wdata    = opnd_q;
    need_div = 1'b0;
    if (cmd_i.div_commit) begin
      we      = 1'b1;
      waddr   = ADDR_W'(level_q - LVL_W'(2));
      wdata   = (op_q == OP_DIV) ? quot : rem;
      level_d = level_q - 1'b1;
      pc_d    = npc;
    end else if (cmd_i.exec) begin
      fault_d = FLT_NONE;
      if (!halt_q) begin
        unique case (op_q)
          OP_HLT: begin
            pc_d   = npc;
            halt_d = 1'b1;
          end
          OP_NEG, OP_NOT, OP_SHL, OP_SHR: begin
            if (level_q == '0) begin
              fault_d = FLT_UNDER;
            end else begin
              we    = 1'b1;
              waddr = ADDR_W'(level_q - 1'b1);
              unique case (op_q)
                OP_NEG:  wdata = W'(0) - rd0;
                OP_NOT:  wdata = ~rd0;
                OP_SHL:  wdata = shl_v;
                default: wdata = shr_v;
              endcase
              pc_d = npc;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_XOR,
          OP_EQ, OP_NEQ, OP_LT, OP_LE, OP_GT, OP_GE: begin
            if (level_q < LVL_W'(2)) begin
              fault_d = FLT_UNDER;
            end else if ((op_q == OP_DIV || op_q == OP_MOD) && rd0 == '0) begin
              fault_d = FLT_DIVZ;
            end else if (op_q == OP_DIV || op_q == OP_MOD) begin
              need_div = 1'b1;
            end else begin
              we      = 1'b1;
              waddr   = ADDR_W'(level_q - LVL_W'(2));
              wdata   = alu;
              level_d = level_q - 1'b1;
              pc_d    = npc;
            end
          end
          OP_POP: begin
            if (opnd_q[W-1]) begin
              fault_d = FLT_INDEX;
            end else if (opnd_x > lvl_x) begin
              fault_d = FLT_UNDER;
            end else begin
              level_d = LVL_W'(lvl_x - opnd_x);
              pc_d    = npc;
            end
          end
          OP_RET: begin
            if (level_q == '0) begin
              fault_d = FLT_UNDER;
            end else begin
              pc_d    = rd0;
              level_d = level_q - 1'b1;
            end
          end
          OP_JMP: pc_d = jpc;
          OP_JMPT, OP_JMPF: begin
            if (level_q == '0) begin
              fault_d = FLT_UNDER;
            end else begin
              level_d = level_q - 1'b1;
              pc_d    = ((rd0 != '0) == (op_q == OP_JMPT)) ? jpc : npc;
            end
          end
          OP_CALL, OP_IMM: begin
            if (lvl_x >= CMP_W'(STACK_DEPTH)) begin
              fault_d = FLT_OVER;
            end else begin
              we      = 1'b1;
              wdata   = (op_q == OP_CALL) ? npc : opnd_q;
              level_d = level_q + 1'b1;
              pc_d    = (op_q == OP_CALL) ? jpc : npc;
            end
          end
          OP_GET: begin
            if (opnd_x >= lvl_x) begin
              fault_d = FLT_INDEX;
            end else if (lvl_x >= CMP_W'(STACK_DEPTH)) begin
              fault_d = FLT_OVER;
            end else begin
              we      = 1'b1;
              wdata   = rd1;
              level_d = level_q + 1'b1;
              pc_d    = npc;
            end
          end
          OP_SET: begin
            if (opnd_q == '0) begin
              pc_d = npc;
            end else if (level_q == '0) begin
              fault_d = FLT_UNDER;
            end else if (opnd_q[W-1] || opnd_x >= lvl_x) begin
              fault_d = FLT_INDEX;
            end else begin
              we      = 1'b1;
              waddr   = ADDR_W'(lvl_x - CMP_W'(1) - opnd_x);
              wdata   = rd0;
              level_d = level_q - 1'b1;
              pc_d    = npc;
            end
          end
          default: pc_d = npc;
        endcase
      end
    end
  end

  assign div_start = cmd_i.exec && need_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      pc_q     <= '0;
      halt_q   <= 1'b0;
      fault_q  <= FLT_NONE;
      ovalid_q <= 1'b0;
    end else begin
      level_q <= level_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      fault_q <= fault_d;
      if (cmd_i.out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(in_cmd);
      opnd_q <= in_opnd;
    end
    if (cmd_i.out_load) begin
      odata_q <= {3'b000, fault_q, halt_q, pc_q, 9'(level_q),
                  (level_q != '0) ? rd0 : W'(0)};
    end
  end

  assign sts_o.need_div = need_div;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o    = ovalid_q;
  assign out_data_o     = odata_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(level_q) <= STACK_DEPTH)
    else $error("stack level beyond depth");
  a_fault_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && fault_d != FLT_NONE) |=> $stable(level_q) && $stable(pc_q))
    else $error("faulting item changed state");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

endmodule

### src/stack_machine_execute_unit_core.sv
// Stack machine execute unit: one instruction per item, one result item each.
// Each item runs through the execute, top-read and output states around the stack RAM;
// divide and modulo wait in a divide state between execute and top read. A new item
// is accepted only after the previous result has been loaded into the output register.
// Reset clears level, pc, halt flag and handshake state; the stack RAM is not cleared.
module stack_machine_execute_unit_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [smeu_pkg::IN_W-1:0]  s_axis_tdata,  // cmd, operand
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [smeu_pkg::OUT_W-1:0] m_axis_tdata   // top_value, stack_count,
                                                    // program_counter, halted, fault
);
  import smeu_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  smeu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smeu_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
